@@ rtl/dual_monod_cell_rates_top_defines.svh @@
// assertion macros for the dual monod cell rates checker
// used by dmc_chk.sv, no other dependencies
`ifndef DUAL_MONOD_CELL_RATES_TOP_DEFINES_SVH
`define DUAL_MONOD_CELL_RATES_TOP_DEFINES_SVH

// same-cycle implication, sampled on clk, off while in reset
`define DMC_CHK_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define DMC_CHK_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

@@ rtl/dmc_pkg.sv @@
// shared constants, types and saturation helper for the dual monod cell rates block
// no dependencies
`default_nettype none

package dmc_pkg;

    // quotient and product width; intermediate values clip at 2^(QW-1)
    localparam int QW = 53;
    localparam int VW = 48;
    localparam int OW = 49;
    localparam int SW = 56;
    localparam int YW = 33;
    localparam int CIW = 4;

    localparam logic signed [SW-1:0] OUT_MAX = 56'sd281474976710655;
    localparam logic signed [SW-1:0] OUT_MIN = -56'sd281474976710656;

    typedef enum logic [CIW-1:0] {
        REG_MAX_GROWTH  = 4'd0,
        REG_NITRITE_K   = 4'd1,
        REG_OXYGEN_K    = 4'd2,
        REG_YIELD       = 4'd3,
        REG_MAINTENANCE = 4'd4,
        REG_DECAY       = 4'd5,
        REG_REACT_EN    = 4'd6,
        REG_GROWTH_EN   = 4'd7
    } cfg_reg_t;

    function automatic logic [OW-1:0] sat_out(input logic signed [SW-1:0] v);
        logic [OW-1:0] r;
        if (v > OUT_MAX)
            r = OUT_MAX[OW-1:0];
        else if (v < OUT_MIN)
            r = OUT_MIN[OW-1:0];
        else
            r = v[OW-1:0];
        return r;
    endfunction

endpackage

`default_nettype wire

@@ rtl/dmc_mul.sv @@
// pipelined fixed point multiply: four partial products, sum, shift and clip
// depends on dmc_pkg
`default_nettype none

module dmc_mul #(
    parameter int AW = 48,
    parameter int BW = 53,
    parameter int F  = 32
) (
    input  wire logic                    clk,
    input  wire logic                    ce,
    input  wire logic [AW-1:0]           a,
    input  wire logic [BW-1:0]           b,
    output logic      [dmc_pkg::QW-1:0]  p
);

    localparam int AL = (AW + 1) / 2;
    localparam int AH = AW - AL;
    localparam int BL = (BW + 1) / 2;
    localparam int BH = BW - BL;
    localparam int PW = AW + BW;
    localparam int QW = dmc_pkg::QW;
    localparam logic [PW-1:0] CAP = PW'(1) << (QW - 1);

    logic [AL+BL-1:0] ll_reg;
    logic [AL+BH-1:0] lh_reg;
    logic [AH+BL-1:0] hl_reg;
    logic [AH+BH-1:0] hh_reg;
    logic [PW-1:0]    sum_reg;
    logic [PW-1:0]    sum_next;
    logic [PW-1:0]    sh;
    logic [QW-1:0]    p_reg;

    always_comb
    begin
        sum_next = PW'(ll_reg) + (PW'(lh_reg) << BL) + (PW'(hl_reg) << AL)
                 + (PW'(hh_reg) << (AL + BL));
        sh = sum_reg >> F;
    end

    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            ll_reg  <= a[AL-1:0] * b[BL-1:0];
            lh_reg  <= a[AL-1:0] * b[BW-1:BL];
            hl_reg  <= a[AW-1:AL] * b[BL-1:0];
            hh_reg  <= a[AW-1:AL] * b[BW-1:BL];
            sum_reg <= sum_next;
            p_reg   <= (sh > CAP) ? CAP[QW-1:0] : sh[QW-1:0];
        end
    end

    assign p = p_reg;

endmodule

`default_nettype wire

@@ rtl/dmc_div.sv @@
// pipelined restoring divider, (num << F) / den, one quotient bit per stage
// zero divisor gives zero, quotient clips at 2^(QW-1); depends on dmc_pkg
`default_nettype none

module dmc_div #(
    parameter int NW = 48,
    parameter int DW = 49,
    parameter int F  = 32
) (
    input  wire logic                    clk,
    input  wire logic                    ce,
    input  wire logic [NW-1:0]           num,
    input  wire logic [DW-1:0]           den,
    output logic      [dmc_pkg::QW-1:0]  quo
);

    localparam int QW = dmc_pkg::QW;
    localparam int XW = NW + F;
    localparam int CW = XW + DW;
    localparam logic [QW-1:0] CAP = QW'(1) << (QW - 1);

    logic [XW-1:0] dvd;
    logic [XW-1:0] hi;

    logic [DW-1:0] rem_reg [QW+1];
    logic [QW-1:0] q_reg   [QW+1];
    logic [QW-1:0] lo_reg  [QW+1];
    logic [DW-1:0] den_reg [QW+1];
    logic          ovf_reg [QW+1];
    logic          zero_reg[QW+1];
    logic [QW-1:0] quo_reg;

    always_comb
    begin
        dvd = {num, {F{1'b0}}};
        hi  = dvd >> QW;
    end

    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            rem_reg[0]  <= hi[DW-1:0];
            q_reg[0]    <= '0;
            lo_reg[0]   <= dvd[QW-1:0];
            den_reg[0]  <= den;
            ovf_reg[0]  <= CW'(hi) >= CW'(den);
            zero_reg[0] <= den == '0;
        end
    end

    for (genvar k = 0; k < QW; k++)
    begin : g_bit
        logic [DW:0] t;
        logic        ge;
        logic [DW:0] diff;

        always_comb
        begin
            t    = {rem_reg[k], lo_reg[k][QW-1-k]};
            ge   = t >= {1'b0, den_reg[k]};
            diff = t - {1'b0, den_reg[k]};
        end

        always_ff @(posedge clk)
        begin
            if (ce)
            begin
                rem_reg[k+1]  <= ge ? diff[DW-1:0] : t[DW-1:0];
                q_reg[k+1]    <= {q_reg[k][QW-2:0], ge};
                lo_reg[k+1]   <= lo_reg[k];
                den_reg[k+1]  <= den_reg[k];
                ovf_reg[k+1]  <= ovf_reg[k];
                zero_reg[k+1] <= zero_reg[k];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            if (zero_reg[QW])
                quo_reg <= '0;
            else if (ovf_reg[QW] || q_reg[QW] > CAP)
                quo_reg <= CAP;
            else
                quo_reg <= q_reg[QW];
        end
    end

    assign quo = quo_reg;

endmodule

`default_nettype wire

@@ rtl/dual_monod_cell_rates_top.sv @@
// dual monod kinetics per grid cell: reaction increments and net growth rate
// Channels: s_axis takes one cell per beat (three 48-bit concentrations in
// tdata, ghost flag in tuser); m_axis gives one result beat per cell with
// four 49-bit signed fields in tdata and the growth-valid flag in tuser.
// cfg_* writes one register per beat (index, data); only write while idle.
// Path to m_axis: the input register loads on the accepting edge, then
// two 55-stage divider chains (monod fractions, then the per-yield
// quotient) and four 3-stage multipliers in series, then the output
// register, from which the result is offered on m_axis.
// Throughput: one cell per cycle; a new beat is taken every cycle while
// the output side keeps up.
// Reset clears all valid bits and loads register defaults (yield 1.0, both
// enables on, the rest zero).
// When m_axis stalls with a result held, the whole pipeline freezes and
// s_axis_tready drops; nothing is lost or repeated.
// depends on dmc_pkg, dmc_mul, dmc_div
`default_nettype none

module dual_monod_cell_rates_top #(
    parameter int FRAC_BITS = 32
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        s_axis_tvalid,
    output logic                             s_axis_tready,
    input  wire logic [143:0]                s_axis_tdata,  // nitrite_conc, oxygen_conc, biomass_density
    input  wire logic                        s_axis_tuser,  // is_ghost
    output logic                             m_axis_tvalid,
    input  wire logic                        m_axis_tready,
    output logic [199:0]                     m_axis_tdata,  // nitrite_reac_delta, oxygen_reac_delta,
                                                            // nitrate_reac_delta, net_growth_rate, pad
    output logic                             m_axis_tuser,  // growth_valid
    input  wire logic                        cfg_valid,
    output logic                             cfg_ready,
    input  wire logic [dmc_pkg::CIW-1:0]     cfg_index,
    input  wire logic [dmc_pkg::VW-1:0]      cfg_data
);

    localparam int QW  = dmc_pkg::QW;
    localparam int VW  = dmc_pkg::VW;
    localparam int OW  = dmc_pkg::OW;
    localparam int SW  = dmc_pkg::SW;
    localparam int YW  = dmc_pkg::YW;
    localparam int LD  = QW + 2;
    localparam int LM  = 3;
    localparam int TOT = 2 * LD + 4 * LM;
    localparam int MGW = 42;
    localparam logic [63:0] ONE15 = ((64'd115 << FRAC_BITS) + 64'd50) / 64'd100;
    localparam logic [63:0] YRST  = 64'd1 << FRAC_BITS;

    // configuration
    logic [VW-1:0] mu_reg, kn_reg, ko_reg, maint_reg, decay_reg;
    logic [YW-1:0] yield_reg;
    logic          react_en_reg, growth_en_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mu_reg        <= '0;
            kn_reg        <= '0;
            ko_reg        <= '0;
            yield_reg     <= YRST[YW-1:0];
            maint_reg     <= '0;
            decay_reg     <= '0;
            react_en_reg  <= 1'b1;
            growth_en_reg <= 1'b1;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                dmc_pkg::REG_MAX_GROWTH:  mu_reg        <= cfg_data;
                dmc_pkg::REG_NITRITE_K:   kn_reg        <= cfg_data;
                dmc_pkg::REG_OXYGEN_K:    ko_reg        <= cfg_data;
                dmc_pkg::REG_YIELD:       yield_reg     <= cfg_data[YW-1:0];
                dmc_pkg::REG_MAINTENANCE: maint_reg     <= cfg_data;
                dmc_pkg::REG_DECAY:       decay_reg     <= cfg_data;
                dmc_pkg::REG_REACT_EN:    react_en_reg  <= cfg_data[0];
                dmc_pkg::REG_GROWTH_EN:   growth_en_reg <= cfg_data[0];
                default: ;
            endcase
        end
    end

    // oxygen coefficient 1.15 - Y, sign kept apart
    logic signed [64:0] coef;
    logic               coef_neg;
    logic [64:0]        coef_mag;

    always_comb
    begin
        coef     = $signed({1'b0, ONE15}) - $signed({32'b0, yield_reg});
        coef_neg = coef < 0;
        coef_mag = coef_neg ? 65'(-coef) : 65'(coef);
    end

    // pipeline advance: frozen only while a result is held
    logic ce;
    logic out_valid_reg;

    assign ce            = !out_valid_reg || m_axis_tready;
    assign s_axis_tready = ce;

    // input register
    logic          in_valid_reg;
    logic [VW-1:0] n_reg, o_reg, x_reg;
    logic          ghost_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (ce)
            in_valid_reg <= s_axis_tvalid;
    end

    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            n_reg     <= s_axis_tdata[47:0];
            o_reg     <= s_axis_tdata[95:48];
            x_reg     <= s_axis_tdata[143:96];
            ghost_reg <= s_axis_tuser;
        end
    end

    // monod fractions
    logic [QW-1:0] fn, fo;

    dmc_div #(.NW(VW), .DW(VW + 1), .F(FRAC_BITS)) u_div_fn (
        .clk (clk),
        .ce  (ce),
        .num (n_reg),
        .den ({1'b0, kn_reg} + {1'b0, n_reg}),
        .quo (fn)
    );

    dmc_div #(.NW(VW), .DW(VW + 1), .F(FRAC_BITS)) u_div_fo (
        .clk (clk),
        .ce  (ce),
        .num (o_reg),
        .den ({1'b0, ko_reg} + {1'b0, o_reg}),
        .quo (fo)
    );

    // tmp1 = mu * fn * fo, tmp2 = m * fo
    logic [QW-1:0] tmp1a, tmp1, tmp2;
    logic [QW-1:0] fo_dly [LM];

    dmc_mul #(.AW(VW), .BW(QW), .F(FRAC_BITS)) u_mul_mufn (
        .clk (clk), .ce (ce), .a (mu_reg), .b (fn), .p (tmp1a)
    );

    dmc_mul #(.AW(VW), .BW(QW), .F(FRAC_BITS)) u_mul_tmp2 (
        .clk (clk), .ce (ce), .a (maint_reg), .b (fo), .p (tmp2)
    );

    dmc_mul #(.AW(QW), .BW(QW), .F(FRAC_BITS)) u_mul_tmp1 (
        .clk (clk), .ce (ce), .a (tmp1a), .b (fo_dly[LM-1]), .p (tmp1)
    );

    // delay lines that keep side values aligned with the arithmetic
    logic [QW-1:0] tmp2_dly  [LM];
    logic [VW-1:0] x_dly     [LD + 2 * LM];
    logic          ghost_dly [TOT];
    logic          vld_dly   [TOT];
    logic [QW-1:0] tmp1_f    [LD + 2 * LM];
    logic [QW-1:0] tmp2_f    [LD + 2 * LM];
    logic [QW-1:0] m2_dly    [LD + LM];
    logic [QW-1:0] py_dly    [LM];

    logic [QW-1:0] g, m2, py, gm, extra;

    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            fo_dly[0]    <= fo;
            tmp2_dly[0]  <= tmp2;
            x_dly[0]     <= x_reg;
            ghost_dly[0] <= ghost_reg;
            tmp1_f[0]    <= tmp1;
            tmp2_f[0]    <= tmp2_dly[LM-1];
            m2_dly[0]    <= m2;
            py_dly[0]    <= py;
            for (int i = 1; i < LM; i++)
            begin
                fo_dly[i]   <= fo_dly[i-1];
                tmp2_dly[i] <= tmp2_dly[i-1];
                py_dly[i]   <= py_dly[i-1];
            end
            for (int i = 1; i < LD + 2 * LM; i++)
            begin
                x_dly[i]  <= x_dly[i-1];
                tmp1_f[i] <= tmp1_f[i-1];
                tmp2_f[i] <= tmp2_f[i-1];
            end
            for (int i = 1; i < LD + LM; i++)
                m2_dly[i] <= m2_dly[i-1];
            for (int i = 1; i < TOT; i++)
                ghost_dly[i] <= ghost_dly[i-1];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < TOT; i++)
                vld_dly[i] <= 1'b0;
        end
        else if (ce)
        begin
            vld_dly[0] <= in_valid_reg;
            for (int i = 1; i < TOT; i++)
                vld_dly[i] <= vld_dly[i-1];
        end
    end

    // biomass scaled terms
    dmc_mul #(.AW(QW), .BW(VW), .F(FRAC_BITS)) u_mul_g (
        .clk (clk), .ce (ce), .a (tmp1), .b (x_dly[LD + 2 * LM - 1]), .p (g)
    );

    dmc_mul #(.AW(QW), .BW(VW), .F(FRAC_BITS)) u_mul_m (
        .clk (clk), .ce (ce), .a (tmp2_dly[LM-1]), .b (x_dly[LD + 2 * LM - 1]), .p (m2)
    );

    // per-yield terms
    dmc_div #(.NW(QW), .DW(YW), .F(FRAC_BITS)) u_div_py (
        .clk (clk), .ce (ce), .num (g), .den (yield_reg), .quo (py)
    );

    dmc_mul #(.AW(MGW), .BW(QW), .F(FRAC_BITS)) u_mul_coef (
        .clk (clk), .ce (ce), .a (coef_mag[MGW-1:0]), .b (g), .p (gm)
    );

    dmc_div #(.NW(QW), .DW(YW), .F(FRAC_BITS)) u_div_ex (
        .clk (clk), .ce (ce), .num (gm), .den (yield_reg), .quo (extra)
    );

    // final combine and saturation
    logic signed [SW-1:0] py_s, ex_s, m2_s, t1_s, t2_s, b_s;
    logic signed [SW-1:0] oxy_s, net_s;
    logic                 react;
    logic [OW-1:0]        nitrite_next, oxygen_next, nitrate_next, net_next;

    always_comb
    begin
        py_s  = $signed({3'b0, py_dly[LM-1]});
        ex_s  = $signed({3'b0, extra});
        m2_s  = $signed({3'b0, m2_dly[LD + LM - 1]});
        t1_s  = $signed({3'b0, tmp1_f[LD + 2 * LM - 1]});
        t2_s  = $signed({3'b0, tmp2_f[LD + 2 * LM - 1]});
        b_s   = $signed({8'b0, decay_reg});
        if (coef_neg)
            ex_s = -ex_s;
        oxy_s = -(ex_s + m2_s);
        net_s = t1_s - t2_s - b_s;
        react = react_en_reg && !ghost_dly[TOT-1];
        nitrite_next = react ? dmc_pkg::sat_out(-py_s) : '0;
        oxygen_next  = react ? dmc_pkg::sat_out(oxy_s) : '0;
        nitrate_next = react ? dmc_pkg::sat_out(py_s) : '0;
        net_next     = growth_en_reg ? dmc_pkg::sat_out(net_s) : '0;
    end

    // output register
    logic [199:0] tdata_reg;
    logic         tuser_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (ce)
            out_valid_reg <= vld_dly[TOT-1];
    end

    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            tdata_reg <= {4'b0, net_next, nitrate_next, oxygen_next, nitrite_next};
            tuser_reg <= growth_en_reg;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = tdata_reg;
    assign m_axis_tuser  = tuser_reg;

endmodule

`default_nettype wire

@@ rtl/dmc_chk.sv @@
// port-level checker for dual_monod_cell_rates_top, attached by bind
// depends on dual_monod_cell_rates_top_defines.svh
`default_nettype none

`include "dual_monod_cell_rates_top_defines.svh"

module dmc_chk (
    input wire logic         clk,
    input wire logic         rst_n,
    input wire logic         s_axis_tready,
    input wire logic         m_axis_tvalid,
    input wire logic         m_axis_tready,
    input wire logic [199:0] m_axis_tdata,
    input wire logic         m_axis_tuser
);

    // result held while the receiver stalls
    `DMC_CHK_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata), "result beat changed under stall")

    // input side only blocks behind a held result
    `DMC_CHK_NOW(a_in_block, !s_axis_tready, m_axis_tvalid && !m_axis_tready, "input blocked without output stall")

    // nitrate increment is never negative
    `DMC_CHK_NOW(a_nitrate_sign, m_axis_tvalid, !m_axis_tdata[146], "negative nitrate increment")

    // growth rate zero when not flagged valid
    `DMC_CHK_NOW(a_growth_off, m_axis_tvalid && !m_axis_tuser, m_axis_tdata[195:147] == 49'd0, "growth rate set while invalid")

endmodule

bind dual_monod_cell_rates_top dmc_chk u_dmc_chk (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);

`default_nettype wire
